FILE: hw/rtl/ezp_pkg.sv
// ----------------------------------------------------------------------------
// ezp_pkg
// Shared types, constants and fixed-point helpers for the Z-Y-X Euler angle
// to pose matrix pipeline.
// ----------------------------------------------------------------------------
package ezp_pkg;

  localparam int AngW = 16;
  localparam int TrW  = 32;
  localparam int RotW = 16;

  // Angles in 1/128 degree
  localparam int Turn    = 46080;
  localparam int Quarter = 11520;

  // r * pi_q30 / 23040 split as r * XkHi + (r * XkLo + RadRnd) / 23040
  localparam int XkHi    = 146408;
  localparam int XkLo    = 19106;
  localparam int RadRnd  = 11520;
  // floor(2^24 / 45), one correction step afterwards
  localparam int Recip45 = 372827;
  localparam int Div45   = 45;

  localparam logic signed [31:0] Q30One = 32'sd1073741824;

  // Horner divisors, sine padded in front with a pass-through step
  localparam int HornerN = 7;
  localparam int unsigned SinK [HornerN] = '{0, 156, 110, 72, 42, 20, 6};
  localparam int unsigned CosK [HornerN] = '{182, 132, 90, 56, 30, 12, 2};

  // Cells' pipeline depth
  localparam int CellLat = 6;

  typedef struct packed {
    logic signed [AngW-1:0] yaw_angle;
    logic signed [AngW-1:0] pitch_angle;
    logic signed [AngW-1:0] roll_angle;
    logic signed [TrW-1:0]  trans_x;
    logic signed [TrW-1:0]  trans_y;
    logic signed [TrW-1:0]  trans_z;
  } ezp_in_t;

  typedef struct packed {
    logic signed [RotW-1:0] r00;
    logic signed [RotW-1:0] r01;
    logic signed [RotW-1:0] r02;
    logic signed [RotW-1:0] r10;
    logic signed [RotW-1:0] r11;
    logic signed [RotW-1:0] r12;
    logic signed [RotW-1:0] r20;
    logic signed [RotW-1:0] r21;
    logic signed [RotW-1:0] r22;
    logic signed [TrW-1:0]  out_x;
    logic signed [TrW-1:0]  out_y;
    logic signed [TrW-1:0]  out_z;
  } ezp_out_t;

  // Argument that travels down the Horner chain
  typedef struct packed {
    logic [30:0] x;
    logic [1:0]  quad;
    logic [31:0] x2;
  } ezp_arg_t;

  typedef struct packed {
    logic signed [31:0] s;
    logic signed [31:0] c;
  } ezp_sc_t;

  // Q30 product back to Q30, half away from zero
  function automatic logic signed [37:0] rnd_q30(input logic signed [67:0] p);
    logic [67:0] mag;
    logic [37:0] m;
    mag = p[67] ? 68'(-p) : 68'(p);
    m   = 38'((mag + 68'd536870912) >> 30);
    return p[67] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] clamp_one(input logic signed [37:0] v);
    logic signed [37:0] r;
    r = v;
    if (v > 38'(Q30One)) r = 38'(Q30One);
    if (v < -38'(Q30One)) r = -38'(Q30One);
    return 32'(r);
  endfunction

  // Q30 to Q1.14, half away from zero, saturated to +-1
  function automatic logic signed [15:0] to_q14(input logic signed [32:0] v);
    logic [32:0]        mag;
    logic [16:0]        m;
    logic signed [16:0] s;
    mag = v[32] ? 33'(-v) : 33'(v);
    m   = 17'((mag + 33'd32768) >> 16);
    if (m > 17'd16384) m = 17'd16384;
    s = $signed(m);
    if (v[32]) s = -s;
    return $signed(s[15:0]);
  endfunction

endpackage

FILE: hw/rtl/ezp_horner_cell.sv
// ----------------------------------------------------------------------------
// ezp_horner_cell
// One Horner step t = 1 - round(x2*t)/K for the sine and cosine series, or a
// pass-through where K is 0; six pipeline stages, argument handed on alongside.
// ----------------------------------------------------------------------------
module ezp_horner_cell
  import ezp_pkg::*;
#(
  parameter int unsigned KS = 0,
  parameter int unsigned KC = 1
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  ezp_arg_t           arg_i,
  input  logic signed [33:0] ts_i,
  input  logic signed [33:0] tc_i,
  output ezp_arg_t           arg_o,
  output logic signed [33:0] ts_o,
  output logic signed [33:0] tc_o
);

  ezp_arg_t           arg_q [CellLat];
  logic signed [33:0] t_in  [2];
  logic signed [33:0] t_out [2];

  assign t_in[0] = ts_i;
  assign t_in[1] = tc_i;
  assign ts_o    = t_out[0];
  assign tc_o    = t_out[1];
  assign arg_o   = arg_q[CellLat-1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      arg_q[0] <= arg_i;
      for (int i = 1; i < CellLat; i++) arg_q[i] <= arg_q[i-1];
    end
  end

  for (genvar j = 0; j < 2; j++) begin : g_t
    localparam int unsigned K = (j == 0) ? KS : KC;

    if (K == 0) begin : g_pass
      logic signed [33:0] d_q [CellLat];
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          d_q[0] <= t_in[j];
          for (int i = 1; i < CellLat; i++) d_q[i] <= d_q[i-1];
        end
      end
      assign t_out[j] = d_q[CellLat-1];
    end else begin : g_step
      // ceil(2^32/K): exact floor division for dividends below 2^24
      localparam logic [31:0] Recip = 32'(((64'd1 << 32) + 64'(K) - 64'd1) / 64'(K));

      logic signed [67:0] prod_q;
      logic               neg_b_q, neg_c_q, neg_d_q, neg_e_q;
      logic [33:0]        mag_q;
      logic [17:0]        mh_q, qh_q, qh_d_q, qh_e_q;
      logic [15:0]        ml_q;
      logic [23:0]        v_q, ql_q;
      logic signed [33:0] t_q;
      logic signed [37:0] rnd_b;
      logic [37:0]        mag_b;
      logic [17:0]        rh_d;
      logic [34:0]        quot_f;
      logic signed [35:0] sq_f, tn_f;

      always_comb begin
        rnd_b  = rnd_q30(prod_q);
        mag_b  = rnd_b[37] ? 38'(-rnd_b) : 38'(rnd_b);
        rh_d   = 18'(mh_q - 18'(qh_q * 18'(K)));
        quot_f = {1'b0, qh_e_q, 16'b0} + 35'(ql_q);
        sq_f   = $signed({1'b0, quot_f});
        if (neg_e_q) sq_f = -sq_f;
        tn_f   = 36'(Q30One) - sq_f;
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          prod_q  <= $signed({1'b0, arg_i.x2}) * t_in[j];
          neg_b_q <= prod_q[67];
          mag_q   <= mag_b[33:0];
          // high half quotient, remainder folded into the low half next
          neg_c_q <= neg_b_q;
          mh_q    <= mag_q[33:16];
          ml_q    <= mag_q[15:0];
          qh_q    <= 18'((64'(mag_q[33:16]) * 64'(Recip)) >> 32);
          neg_d_q <= neg_c_q;
          qh_d_q  <= qh_q;
          v_q     <= {rh_d[7:0], ml_q};
          neg_e_q <= neg_d_q;
          qh_e_q  <= qh_d_q;
          ql_q    <= 24'((64'(v_q) * 64'(Recip)) >> 32);
          t_q     <= $signed(tn_f[33:0]);
        end
      end

      assign t_out[j] = t_q;
    end
  end

endmodule

FILE: hw/rtl/ezp_angle_lane.sv
// ----------------------------------------------------------------------------
// ezp_angle_lane
// Sine and cosine of one angle: wrap, quadrant split, radian conversion,
// chain of Horner cells, quadrant rotation. 51 stages.
// ----------------------------------------------------------------------------
module ezp_angle_lane
  import ezp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [AngW-1:0] angle_i,
  output ezp_sc_t                sc_o
);

  logic signed [16:0] ue;
  logic [15:0]        u;
  logic [1:0]         quad_d;
  logic [15:0]        base;
  logic [18:0]        w;
  logic [31:0]        rem;

  logic [1:0]  quad_q [5];
  logic [13:0] r_q;
  logic [30:0] a_q, a3_q, x_q, x5_q;
  logic [27:0] v_q;
  logic [18:0] w_q;
  logic [13:0] q0_q;
  logic [61:0] xx_q;
  ezp_arg_t    arg6_q;

  ezp_arg_t           arg_w [HornerN+1];
  logic signed [33:0] ts_w  [HornerN+1];
  logic signed [33:0] tc_w  [HornerN+1];

  logic signed [67:0] sprod_q;
  logic signed [31:0] c7_q, c8_q, s8_q;
  logic [1:0]         quad7_q, quad8_q;
  ezp_sc_t            sc_q;

  always_comb begin
    ue = angle_i[15] ? 17'(angle_i) + 17'sd46080 : 17'(angle_i);
    u  = ue[15:0];
    if (u >= 16'(3 * Quarter)) begin
      quad_d = 2'd3;
      base   = 16'(3 * Quarter);
    end else if (u >= 16'(2 * Quarter)) begin
      quad_d = 2'd2;
      base   = 16'(2 * Quarter);
    end else if (u >= 16'(Quarter)) begin
      quad_d = 2'd1;
      base   = 16'(Quarter);
    end else begin
      quad_d = 2'd0;
      base   = 16'd0;
    end
    w   = v_q[27:9];
    rem = 32'(w_q) - 32'(q0_q) * 32'(Div45);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_q[0] <= quad_d;
      r_q       <= 14'(u - base);
      quad_q[1] <= quad_q[0];
      a_q       <= 31'(32'(r_q) * 32'(XkHi));
      v_q       <= 28'(32'(r_q) * 32'(XkLo) + 32'(RadRnd));
      quad_q[2] <= quad_q[1];
      a3_q      <= a_q;
      w_q       <= w;
      q0_q      <= 14'((64'(w) * 64'(Recip45)) >> 24);
      quad_q[3] <= quad_q[2];
      x_q       <= a3_q + 31'(q0_q) + 31'(rem >= 32'(Div45));
      quad_q[4] <= quad_q[3];
      x5_q      <= x_q;
      xx_q      <= x_q * x_q;
      arg6_q.x    <= x5_q;
      arg6_q.quad <= quad_q[4];
      arg6_q.x2   <= 32'((64'(xx_q) + 64'd536870912) >> 30);
    end
  end

  assign arg_w[0] = arg6_q;
  assign ts_w[0]  = 34'(Q30One);
  assign tc_w[0]  = 34'(Q30One);

  for (genvar c = 0; c < HornerN; c++) begin : g_cell
    ezp_horner_cell #(
      .KS(SinK[c]),
      .KC(CosK[c])
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .arg_i (arg_w[c]),
      .ts_i  (ts_w[c]),
      .tc_i  (tc_w[c]),
      .arg_o (arg_w[c+1]),
      .ts_o  (ts_w[c+1]),
      .tc_o  (tc_w[c+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sprod_q <= $signed({1'b0, arg_w[HornerN].x}) * ts_w[HornerN];
      c7_q    <= clamp_one(38'(tc_w[HornerN]));
      quad7_q <= arg_w[HornerN].quad;
      s8_q    <= clamp_one(rnd_q30(sprod_q));
      c8_q    <= c7_q;
      quad8_q <= quad7_q;
      case (quad8_q)
        2'd0: begin
          sc_q.s <= s8_q;
          sc_q.c <= c8_q;
        end
        2'd1: begin
          sc_q.s <= c8_q;
          sc_q.c <= -s8_q;
        end
        2'd2: begin
          sc_q.s <= -s8_q;
          sc_q.c <= -c8_q;
        end
        default: begin
          sc_q.s <= -c8_q;
          sc_q.c <= s8_q;
        end
      endcase
    end
  end

  assign sc_o = sc_q;

endmodule

FILE: hw/rtl/ezp_pose_mat.sv
// ----------------------------------------------------------------------------
// ezp_pose_mat
// Rz*Ry*Rx entries in Q30 from the three sine/cosine pairs. Four stages:
// first products, round, second products, round and sum.
// ----------------------------------------------------------------------------
module ezp_pose_mat
  import ezp_pkg::*;
(
  input  logic               clk_i,
  input  logic               en_i,
  input  ezp_sc_t            yaw_i,
  input  ezp_sc_t            pitch_i,
  input  ezp_sc_t            roll_i,
  output logic signed [32:0] rot_o [9]
);

  logic signed [31:0] fa [10];
  logic signed [31:0] fb [10];
  logic signed [67:0] p_q [10];
  logic signed [31:0] m_q [10];
  logic signed [31:0] n_q [10];
  logic signed [67:0] q_q [4];
  ezp_sc_t            roll_a_q, roll_b_q;
  logic signed [31:0] sp_a_q, sp_b_q, sp_c_q;
  logic signed [32:0] rot_q [9];
  logic signed [37:0] rq [4];

  // 0 cy*cp, 1 sy*cp, 2 cp*sr, 3 cp*cr, 4 cy*sp, 5 sy*sp,
  // 6 sy*cr, 7 sy*sr, 8 cy*cr, 9 cy*sr
  always_comb begin
    fa[0] = yaw_i.c;   fb[0] = pitch_i.c;
    fa[1] = yaw_i.s;   fb[1] = pitch_i.c;
    fa[2] = pitch_i.c; fb[2] = roll_i.s;
    fa[3] = pitch_i.c; fb[3] = roll_i.c;
    fa[4] = yaw_i.c;   fb[4] = pitch_i.s;
    fa[5] = yaw_i.s;   fb[5] = pitch_i.s;
    fa[6] = yaw_i.s;   fb[6] = roll_i.c;
    fa[7] = yaw_i.s;   fb[7] = roll_i.s;
    fa[8] = yaw_i.c;   fb[8] = roll_i.c;
    fa[9] = yaw_i.c;   fb[9] = roll_i.s;
    for (int k = 0; k < 4; k++) rq[k] = rnd_q30(q_q[k]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 10; i++) begin
        p_q[i] <= 68'(fa[i]) * 68'(fb[i]);
        m_q[i] <= 32'(rnd_q30(p_q[i]));
        n_q[i] <= m_q[i];
      end
      roll_a_q <= roll_i;
      roll_b_q <= roll_a_q;
      sp_a_q   <= pitch_i.s;
      sp_b_q   <= sp_a_q;
      sp_c_q   <= sp_b_q;
      q_q[0]   <= 68'(m_q[4]) * 68'(roll_b_q.s);
      q_q[1]   <= 68'(m_q[4]) * 68'(roll_b_q.c);
      q_q[2]   <= 68'(m_q[5]) * 68'(roll_b_q.s);
      q_q[3]   <= 68'(m_q[5]) * 68'(roll_b_q.c);
      rot_q[0] <= 33'(n_q[0]);
      rot_q[1] <= 33'(rq[0]) - 33'(n_q[6]);
      rot_q[2] <= 33'(rq[1]) + 33'(n_q[7]);
      rot_q[3] <= 33'(n_q[1]);
      rot_q[4] <= 33'(rq[2]) + 33'(n_q[8]);
      rot_q[5] <= 33'(rq[3]) - 33'(n_q[9]);
      rot_q[6] <= -33'(sp_c_q);
      rot_q[7] <= 33'(n_q[2]);
      rot_q[8] <= 33'(n_q[3]);
    end
  end

  assign rot_o = rot_q;

endmodule

FILE: hw/rtl/euler_zyx_to_pose_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_zyx_to_pose_matrix_core
// Yaw/pitch/roll plus translation to a rigid pose R = Rz*Ry*Rx, Q1.14.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: yaw, pitch, roll in 1/128 degree and a Q16.16 translation,
//   on in_valid_i/in_ready_o. Output beat: nine Q1.14 rotation entries and
//   the translation copied, on out_valid_o/out_ready_i.
//   Throughput: one beat per cycle while out_ready_i does not stall the
//   pipeline. Each angle runs through its own lane of seven Horner cells
//   (six stages each), then a four-stage matrix unit; all 56 stages
//   advance together.
//   Stall: when a result waits and out_ready_i is low the whole pipeline
//   holds and in_ready_o drops; it resumes in the cycle out_ready_i rises.
//   Reset: clears all valid flags; no beat is in flight afterwards.
// ----------------------------------------------------------------------------
module euler_zyx_to_pose_matrix_core
  import ezp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ezp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ezp_out_t out_data_o
);

  // lane (51) + matrix (4)
  localparam int Lat = 6 + HornerN * CellLat + 3 + 4;

  logic               en;
  logic               vld_q [Lat];
  logic [3*TrW-1:0]   tr_q  [Lat];
  ezp_sc_t            yaw_sc, pitch_sc, roll_sc;
  logic signed [32:0] rot_w [9];
  logic               out_valid_q;
  ezp_out_t           out_q;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  ezp_angle_lane u_yaw (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_data_i.yaw_angle),
    .sc_o    (yaw_sc)
  );

  ezp_angle_lane u_pitch (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_data_i.pitch_angle),
    .sc_o    (pitch_sc)
  );

  ezp_angle_lane u_roll (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (in_data_i.roll_angle),
    .sc_o    (roll_sc)
  );

  ezp_pose_mat u_mat (
    .clk_i   (clk_i),
    .en_i    (en),
    .yaw_i   (yaw_sc),
    .pitch_i (pitch_sc),
    .roll_i  (roll_sc),
    .rot_o   (rot_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Lat; i++) vld_q[i] <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i < Lat; i++) vld_q[i] <= vld_q[i-1];
      out_valid_q <= vld_q[Lat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tr_q[0] <= {in_data_i.trans_x, in_data_i.trans_y, in_data_i.trans_z};
      for (int i = 1; i < Lat; i++) tr_q[i] <= tr_q[i-1];
      out_q.r00   <= to_q14(rot_w[0]);
      out_q.r01   <= to_q14(rot_w[1]);
      out_q.r02   <= to_q14(rot_w[2]);
      out_q.r10   <= to_q14(rot_w[3]);
      out_q.r11   <= to_q14(rot_w[4]);
      out_q.r12   <= to_q14(rot_w[5]);
      out_q.r20   <= to_q14(rot_w[6]);
      out_q.r21   <= to_q14(rot_w[7]);
      out_q.r22   <= to_q14(rot_w[8]);
      out_q.out_x <= $signed(tr_q[Lat-1][3*TrW-1:2*TrW]);
      out_q.out_y <= $signed(tr_q[Lat-1][2*TrW-1:TrW]);
      out_q.out_z <= $signed(tr_q[Lat-1][TrW-1:0]);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Saturation keeps every entry within +-1.0; checked on r00, r11, r22 and r01
  a_rot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (out_data_o.r00 <= 16'sd16384) && (out_data_o.r00 >= -16'sd16384) &&
      (out_data_o.r11 <= 16'sd16384) && (out_data_o.r11 >= -16'sd16384) &&
      (out_data_o.r22 <= 16'sd16384) && (out_data_o.r22 >= -16'sd16384) &&
      (out_data_o.r01 <= 16'sd16384) && (out_data_o.r01 >= -16'sd16384))
    else $error("rotation entry out of range");

  // A result only appears from the tail of the valid line
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[Lat-1]))
    else $error("result without a beat in flight");

  // A stalled pipeline never drops its tail beat
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> out_valid_o)
    else $error("result lost during stall");

endmodule
